### src/ias_pkg.sv
`default_nettype none

package ias_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int ROW_W    = 26;
   localparam int ROWSQ_W  = 41;
   localparam int AREA_W   = 36;
   localparam int SQ_W     = 51;
   localparam int CFG_W    = 11;

   // register file
   localparam int CSR_INDEX_W     = 1;
   localparam int FRAME_DIM_RESET = 1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // result queue
   localparam int RSP_QUEUE_DEPTH = 8;
   localparam int RSP_QUEUE_PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_QUEUE_CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [ROW_W-1:0]  row_sum;
      logic signed [AREA_W-1:0] area_sum;
      logic [SQ_W-1:0]          area_square_sum;
      logic                     end_of_row;
      logic                     end_of_frame;
   } rsp_word_type;

   typedef struct packed {
      logic                       valid;
      logic [RSP_QUEUE_CNT_W-1:0] level;
   } queue_status_type;

endpackage

`default_nettype wire

### src/ias_rsp_queue.sv
`default_nettype none

module ias_rsp_queue import ias_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rsp_word_type     push_word,
   input  wire logic             pop,
   output rsp_word_type          head_word,
   output queue_status_type      status
);

   rsp_word_type                 words_ff [RSP_QUEUE_DEPTH];
   logic [RSP_QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_QUEUE_CNT_W-1:0]   level_ff;
   logic [RSP_QUEUE_CNT_W-1:0]   level_in;

   // pointers and fill level
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + RSP_QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - RSP_QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_QUEUE_PTR_W'(1);
         end
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         words_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_word    = words_ff[rd_ptr_ff];
   assign status.valid = (level_ff != '0);
   assign status.level = level_ff;

   // no overflow, no underflow, level follows the handshakes
   assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff < RSP_QUEUE_CNT_W'(RSP_QUEUE_DEPTH)) || pop)
      else $error("rsp queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("rsp queue underflow");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (level_ff == $past(level_ff) + RSP_QUEUE_CNT_W'(1)))
      else $error("rsp queue level lost a word");

endmodule

`default_nettype wire

### src/integral_image_sum_and_square.sv
`default_nettype none

// pipeline: an accepted word passes three register stages, a, b and c, and then the result
//   queue before its result shows on the rsp ports
// throughput: one word per cycle; req_stall rises only when the 8-word result queue plus
//   the three stages in flight would be full, i.e. under back pressure on rsp
// reset: counters, running sums, valid bits and queue clear; width and height return to 1024,
//   capped at MAX_WIDTH, MAX_HEIGHT; line buffers are not cleared, first row reads zero above
module integral_image_sum_and_square import ias_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input words
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   // result words
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [ROW_W-1:0]       rsp_row_sum,
   output logic signed [AREA_W-1:0]      rsp_area_sum,
   output logic [SQ_W-1:0]               rsp_area_square_sum,
   output logic                          rsp_end_of_row,
   output logic                          rsp_end_of_frame,
   // register writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CFG_W-1:0]         csr_data
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int RIDX_W  = $clog2(MAX_HEIGHT);
   localparam int WDIM_W  = COL_W + 1;
   localparam int HDIM_W  = RIDX_W + 1;
   localparam int WCMP_W  = (CFG_W > WDIM_W) ? CFG_W : WDIM_W;
   localparam int HCMP_W  = (CFG_W > HDIM_W) ? CFG_W : HDIM_W;
   localparam int PROD_W  = 2 * SAMPLE_BITS;
   localparam int CREDIT_W = RSP_QUEUE_CNT_W + 1;
   localparam logic [WDIM_W-1:0] WIDTH_RESET =
      WDIM_W'((MAX_WIDTH < FRAME_DIM_RESET) ? MAX_WIDTH : FRAME_DIM_RESET);
   localparam logic [HDIM_W-1:0] HEIGHT_RESET =
      HDIM_W'((MAX_HEIGHT < FRAME_DIM_RESET) ? MAX_HEIGHT : FRAME_DIM_RESET);

   // configuration
   logic [WDIM_W-1:0]          width_ff;
   logic [HDIM_W-1:0]          height_ff;
   logic [WCMP_W-1:0]          width_cfg;
   logic [HCMP_W-1:0]          height_cfg;
   logic [WDIM_W-1:0]          width_clamped;
   logic [HDIM_W-1:0]          height_clamped;

   // position and row running sum
   logic                       req_accept;
   logic [COL_W-1:0]           col_ff;
   logic [COL_W-1:0]           col_in;
   logic [RIDX_W-1:0]          row_ff;
   logic [RIDX_W-1:0]          row_in;
   logic signed [ROW_W-1:0]    row_acc_ff;
   logic signed [ROW_W-1:0]    row_acc_in;
   logic signed [ROW_W-1:0]    row_sum_next;
   logic signed [SAMPLE_BITS-1:0] sample_s;
   logic                       last_col;
   logic                       last_row;

   // line buffers
   logic signed [AREA_W-1:0]   area_mem [MAX_WIDTH];
   logic [SQ_W-1:0]            sq_mem [MAX_WIDTH];
   logic signed [AREA_W-1:0]   area_rd_ff;
   logic [SQ_W-1:0]            sq_rd_ff;

   // stage a
   logic                          a_valid_ff;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic [COL_W-1:0]              a_col_ff;
   logic                          a_first_row_ff;
   logic                          a_eor_ff;
   logic                          a_eof_ff;
   logic signed [ROW_W-1:0]       a_row_sum_ff;
   logic signed [PROD_W-1:0]      a_square;

   // stage b
   logic                       b_valid_ff;
   logic [PROD_W-1:0]          b_sq_ff;
   logic signed [AREA_W-1:0]   b_above_area_ff;
   logic [COL_W-1:0]           b_col_ff;
   logic                       b_first_row_ff;
   logic                       b_eor_ff;
   logic                       b_eof_ff;
   logic signed [ROW_W-1:0]    b_row_sum_ff;
   logic signed [AREA_W-1:0]   area_above;
   logic signed [AREA_W-1:0]   area_next;
   logic [ROWSQ_W-1:0]         row_sq_acc_ff;
   logic [ROWSQ_W-1:0]         row_sq_acc_in;
   logic [ROWSQ_W-1:0]         row_sq_next;

   // stage c
   logic                       c_valid_ff;
   logic [COL_W-1:0]           c_col_ff;
   logic                       c_first_row_ff;
   logic                       c_eor_ff;
   logic                       c_eof_ff;
   logic signed [ROW_W-1:0]    c_row_sum_ff;
   logic signed [AREA_W-1:0]   c_area_ff;
   logic [ROWSQ_W-1:0]         c_row_sq_ff;
   logic [SQ_W-1:0]            c_above_sq_ff;
   logic [SQ_W-1:0]            sq_above;
   logic [SQ_W-1:0]            area_sq_next;

   // write history for forwarding
   logic                       d_valid_ff;
   logic [COL_W-1:0]           d_col_ff;
   logic signed [AREA_W-1:0]   d_area_ff;
   logic [SQ_W-1:0]            d_sq_ff;
   logic                       e_valid_ff;
   logic [COL_W-1:0]           e_col_ff;
   logic [SQ_W-1:0]            e_sq_ff;

   // result queue
   rsp_word_type               push_word;
   rsp_word_type               head_word;
   queue_status_type           queue_status;
   logic                       rsp_pop;
   logic [CREDIT_W-1:0]        credit_used;

   // clamp register values to the supported range
   always_comb begin
      width_cfg  = WCMP_W'(csr_data);
      height_cfg = HCMP_W'(csr_data);
      if (width_cfg == '0) begin
         width_clamped = WDIM_W'(1);
      end else if (width_cfg > WCMP_W'(MAX_WIDTH)) begin
         width_clamped = WDIM_W'(MAX_WIDTH);
      end else begin
         width_clamped = WDIM_W'(width_cfg);
      end
      if (height_cfg == '0) begin
         height_clamped = HDIM_W'(1);
      end else if (height_cfg > HCMP_W'(MAX_HEIGHT)) begin
         height_clamped = HDIM_W'(MAX_HEIGHT);
      end else begin
         height_clamped = HDIM_W'(height_cfg);
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff  <= width_clamped;
            CSR_FRAME_HEIGHT: height_ff <= height_clamped;
            default: ;
         endcase
      end
   end

   // accept when the queue has room for every word in flight
   assign credit_used = CREDIT_W'(queue_status.level) + CREDIT_W'(a_valid_ff)
                      + CREDIT_W'(b_valid_ff) + CREDIT_W'(c_valid_ff);
   assign req_stall   = (credit_used >= CREDIT_W'(RSP_QUEUE_DEPTH));
   assign req_accept  = req_valid && !req_stall;

   // raster position and row prefix sum
   assign sample_s = req_sample[SAMPLE_BITS-1:0];

   always_comb begin
      last_col     = (({1'b0, col_ff} + WDIM_W'(1)) >= width_ff);
      last_row     = (({1'b0, row_ff} + HDIM_W'(1)) >= height_ff);
      row_sum_next = row_acc_ff + ROW_W'(sample_s);
      if (last_col) begin
         col_in     = '0;
         row_acc_in = '0;
         row_in     = last_row ? '0 : row_ff + RIDX_W'(1);
      end else begin
         col_in     = col_ff + COL_W'(1);
         row_acc_in = row_sum_next;
         row_in     = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_acc_ff <= '0;
      end else if (req_accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_acc_ff <= row_acc_in;
      end
   end

   // line buffer reads, area at the current column, squares one stage later
   always_ff @(posedge clock) begin
      area_rd_ff <= area_mem[col_ff];
      sq_rd_ff   <= sq_mem[a_col_ff];
      if (b_valid_ff) begin
         area_mem[b_col_ff] <= area_next;
      end
      if (c_valid_ff) begin
         sq_mem[c_col_ff] <= area_sq_next;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         e_valid_ff    <= 1'b0;
         row_sq_acc_ff <= '0;
      end else begin
         a_valid_ff    <= req_accept;
         b_valid_ff    <= a_valid_ff;
         c_valid_ff    <= b_valid_ff;
         d_valid_ff    <= c_valid_ff;
         e_valid_ff    <= d_valid_ff;
         row_sq_acc_ff <= row_sq_acc_in;
      end
   end

   // stage a: sample, position flags and row sum
   always_ff @(posedge clock) begin
      a_sample_ff    <= sample_s;
      a_col_ff       <= col_ff;
      a_first_row_ff <= (row_ff == '0);
      a_eor_ff       <= last_col;
      a_eof_ff       <= last_col && last_row;
      a_row_sum_ff   <= row_sum_next;
   end

   // square of the sample
   assign a_square = a_sample_ff * a_sample_ff;

   always_ff @(posedge clock) begin
      b_sq_ff         <= unsigned'(a_square);
      b_above_area_ff <= area_rd_ff;
      b_col_ff        <= a_col_ff;
      b_first_row_ff  <= a_first_row_ff;
      b_eor_ff        <= a_eor_ff;
      b_eof_ff        <= a_eof_ff;
      b_row_sum_ff    <= a_row_sum_ff;
   end

   // stage b: area from the row above, newest in-flight write wins
   always_comb begin
      priority if (b_first_row_ff) begin
         area_above = '0;
      end else if (c_valid_ff && (c_col_ff == b_col_ff)) begin
         area_above = c_area_ff;
      end else if (d_valid_ff && (d_col_ff == b_col_ff)) begin
         area_above = d_area_ff;
      end else begin
         area_above = b_above_area_ff;
      end
      area_next   = area_above + AREA_W'(b_row_sum_ff);
      row_sq_next = row_sq_acc_ff + ROWSQ_W'(b_sq_ff);
      if (b_valid_ff) begin
         row_sq_acc_in = b_eor_ff ? '0 : row_sq_next;
      end else begin
         row_sq_acc_in = row_sq_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_col_ff       <= b_col_ff;
      c_first_row_ff <= b_first_row_ff;
      c_eor_ff       <= b_eor_ff;
      c_eof_ff       <= b_eof_ff;
      c_row_sum_ff   <= b_row_sum_ff;
      c_area_ff      <= area_next;
      c_row_sq_ff    <= row_sq_next;
      c_above_sq_ff  <= sq_rd_ff;
   end

   // stage c: area of squares, same forwarding scheme one stage later
   always_comb begin
      priority if (c_first_row_ff) begin
         sq_above = '0;
      end else if (d_valid_ff && (d_col_ff == c_col_ff)) begin
         sq_above = d_sq_ff;
      end else if (e_valid_ff && (e_col_ff == c_col_ff)) begin
         sq_above = e_sq_ff;
      end else begin
         sq_above = c_above_sq_ff;
      end
      area_sq_next = sq_above + SQ_W'(c_row_sq_ff);
   end

   always_ff @(posedge clock) begin
      d_col_ff  <= c_col_ff;
      d_area_ff <= c_area_ff;
      d_sq_ff   <= area_sq_next;
      e_col_ff  <= d_col_ff;
      e_sq_ff   <= d_sq_ff;
   end

   // result word into the queue
   always_comb begin
      push_word.row_sum         = c_row_sum_ff;
      push_word.area_sum        = c_area_ff;
      push_word.area_square_sum = area_sq_next;
      push_word.end_of_row      = c_eor_ff;
      push_word.end_of_frame    = c_eof_ff;
   end

   assign rsp_pop = rsp_valid && !rsp_stall;

   ias_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (c_valid_ff),
      .push_word (push_word),
      .pop       (rsp_pop),
      .head_word (head_word),
      .status    (queue_status)
   );

   assign rsp_valid           = queue_status.valid;
   assign rsp_row_sum         = head_word.row_sum;
   assign rsp_area_sum        = head_word.area_sum;
   assign rsp_area_square_sum = head_word.area_square_sum;
   assign rsp_end_of_row      = head_word.end_of_row;
   assign rsp_end_of_frame    = head_word.end_of_frame;

   // frame end only on a row end
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_eof_ff) |-> a_eor_ff)
      else $error("end of frame without end of row");

   // words in flight never exceed the queue space
   assert property (@(posedge clock) disable iff (reset)
      credit_used <= CREDIT_W'(RSP_QUEUE_DEPTH))
      else $error("more words in flight than queue space");

   // a frame end restarts the raster position
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_col && last_row) |=> (col_ff == '0) && (row_ff == '0))
      else $error("position not cleared at end of frame");

   // a row end clears the running row sum
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_col) |=> (row_acc_ff == '0))
      else $error("row sum not cleared at end of row");

endmodule

`default_nettype wire
